>>> hdl/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned RES_CNT_W   = 4;
  localparam int unsigned IDX_CMP_W   = 7;
  localparam logic [7:0]  RUNS_MAX    = 8'd255;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_DEL      = 2'd2,
    FUNC_DISPATCH = 2'd3
  } func_e;

  typedef struct packed {
    logic        valid;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  runs;
  } slot_rec_t;

  typedef struct packed {
    logic claim_open;
    logic del_hit;
    logic disp_open;
  } slot_ctrl_t;

  typedef struct packed {
    logic claimed;
    logic fired;
  } slot_flags_t;

  localparam slot_rec_t SLOT_EMPTY = '{valid: 1'b0, delay: 16'd0, period: 16'd0, runs: 8'd0};

endpackage

>>> hdl/tts_cell.sv
`timescale 1ns / 1ps

module tts_cell
  import tts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  slot_rec_t rec_i,
  output slot_rec_t rec_o
);

  slot_rec_t rec_q;

  // takes the neighbor's record on every shift cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= SLOT_EMPTY;
    end else if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

>>> hdl/tts_slot_op.sv
`timescale 1ns / 1ps

module tts_slot_op
  import tts_pkg::*;
(
  input  func_e       func_i,
  input  logic [15:0] delay_i,
  input  logic [15:0] period_i,
  input  slot_ctrl_t  ctrl_i,
  input  slot_rec_t   rec_i,
  output slot_rec_t   rec_o,
  output slot_flags_t flags_o
);

  always_comb begin
    rec_o   = rec_i;
    flags_o = '0;
    unique case (func_i)
      FUNC_TICK: begin
        if (rec_i.valid) begin
          if (rec_i.delay == 16'd0) begin
            if (rec_i.runs != RUNS_MAX) begin
              rec_o.runs = rec_i.runs + 8'd1;
            end
            if (rec_i.period != 16'd0) begin
              rec_o.delay = rec_i.period;
            end
          end else begin
            rec_o.delay = rec_i.delay - 16'd1;
          end
        end
      end
      FUNC_ADD: begin
        if (!rec_i.valid && ctrl_i.claim_open) begin
          rec_o.valid     = 1'b1;
          rec_o.delay     = delay_i;
          rec_o.period    = period_i;
          rec_o.runs      = 8'd0;
          flags_o.claimed = 1'b1;
        end
      end
      FUNC_DEL: begin
        if (ctrl_i.del_hit) begin
          rec_o = SLOT_EMPTY;
        end
      end
      FUNC_DISPATCH: begin
        if (rec_i.runs != 8'd0 && ctrl_i.disp_open) begin
          flags_o.fired = 1'b1;
          if (rec_i.period == 16'd0) begin
            rec_o = SLOT_EMPTY;
          end else begin
            rec_o.runs = rec_i.runs - 8'd1;
          end
        end
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
  end

endmodule

>>> hdl/time_triggered_task_scheduler_top.sv
`timescale 1ns / 1ps

// channel  | direction | ports                                           | handshake
// ---------+-----------+-------------------------------------------------+--------------------
// command  | in        | func_i, delay_i, period_i, task_index_i         | start & !busy
// result   | out       | slot_o, due_o, status_o, last_o                 | result_valid_o
//
// an item goes from its accept cycle in idle through the rotation (ST_RUN), one slot record
// past the update unit per cycle, and through the closing state (ST_FINISH) back to idle;
// busy is high in the rotation and in the closing state
// the first result of a dispatch may appear during the rotation, the last one follows it
// reset clears every slot record and the control, results come one per cycle at most
// results cannot be stalled, busy holds off new commands until the rotation is done

module time_triggered_task_scheduler_top
  import tts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [15:0] delay_i,
  input  logic [15:0] period_i,
  input  logic [2:0]  task_index_i,
  output logic        result_valid_o,
  output logic [3:0]  slot_o,
  output logic        due_o,
  output logic        status_o,
  output logic        last_o
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IW-1:0] CNT_LAST = IW'(TASK_SLOTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(TASK_SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  state_e               state_q;
  logic [IW-1:0]        cnt_q;
  func_e                func_q;
  logic [15:0]          delay_q;
  logic [15:0]          period_q;
  logic [2:0]           idx_q;
  logic                 claim_done_q;
  logic [SLOT_W-1:0]    claim_slot_q;
  logic                 held_valid_q;
  logic [SLOT_W-1:0]    held_slot_q;
  logic [RES_CNT_W-1:0] n_q;

  logic                 res_valid_q;
  logic [SLOT_W-1:0]    res_slot_q;
  logic                 res_due_q;
  logic                 res_status_q;
  logic                 res_last_q;

  slot_rec_t   ring [TASK_SLOTS];
  slot_rec_t   head_next;
  slot_ctrl_t  ctrl;
  slot_flags_t flags;
  logic        shift;
  logic [SLOT_W-1:0] cnt_slot;
  logic        idx_in_range;

  assign shift        = (state_q == ST_RUN);
  assign cnt_slot     = SLOT_W'(cnt_q);
  assign idx_in_range = IDX_CMP_W'(idx_q) < IDX_CMP_W'(TASK_SLOTS);

  assign ctrl.claim_open = !claim_done_q;
  assign ctrl.del_hit    = IDX_CMP_W'(cnt_q) == IDX_CMP_W'(idx_q);
  assign ctrl.disp_open  = n_q < RES_CNT_W'(MAX_RESULTS);

  // update unit sits at the head of the ring, ring[0] always holds slot cnt_q
  tts_slot_op u_slot_op (
    .func_i   (func_q),
    .delay_i  (delay_q),
    .period_i (period_q),
    .ctrl_i   (ctrl),
    .rec_i    (ring[0]),
    .rec_o    (head_next),
    .flags_o  (flags)
  );

  // ring of slot cells, the updated head record re-enters at the tail
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    slot_rec_t rec_in;
    if (i == TASK_SLOTS - 1) begin : g_tail
      assign rec_in = head_next;
    end else begin : g_mid
      assign rec_in = ring[i+1];
    end
    tts_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .rec_i   (rec_in),
      .rec_o   (ring[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      func_q       <= FUNC_TICK;
      delay_q      <= '0;
      period_q     <= '0;
      idx_q        <= '0;
      claim_done_q <= 1'b0;
      claim_slot_q <= '0;
      held_valid_q <= 1'b0;
      held_slot_q  <= '0;
      n_q          <= '0;
      res_valid_q  <= 1'b0;
      res_slot_q   <= '0;
      res_due_q    <= 1'b0;
      res_status_q <= 1'b0;
      res_last_q   <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            func_q       <= func_e'(func_i);
            delay_q      <= delay_i;
            period_q     <= period_i;
            idx_q        <= task_index_i;
            cnt_q        <= '0;
            claim_done_q <= 1'b0;
            held_valid_q <= 1'b0;
            n_q          <= '0;
            state_q      <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (flags.claimed) begin
            claim_done_q <= 1'b1;
            claim_slot_q <= cnt_slot;
          end
          // a due slot is held back one find so its last flag is known
          if (flags.fired) begin
            if (held_valid_q) begin
              res_valid_q  <= 1'b1;
              res_slot_q   <= held_slot_q;
              res_due_q    <= 1'b1;
              res_status_q <= 1'b0;
              res_last_q   <= 1'b0;
            end
            held_valid_q <= 1'b1;
            held_slot_q  <= cnt_slot;
            n_q          <= n_q + RES_CNT_W'(1);
          end
          if (cnt_q == CNT_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_FINISH;
          end else begin
            cnt_q <= cnt_q + IW'(1);
          end
        end
        ST_FINISH: begin
          res_valid_q  <= 1'b1;
          res_due_q    <= 1'b0;
          res_status_q <= 1'b0;
          res_last_q   <= 1'b1;
          res_slot_q   <= SLOT_NONE;
          unique case (func_q)
            FUNC_TICK: begin
              res_slot_q <= SLOT_NONE;
            end
            FUNC_ADD: begin
              if (claim_done_q) begin
                res_slot_q <= claim_slot_q;
              end else begin
                res_status_q <= 1'b1;
              end
            end
            FUNC_DEL: begin
              if (idx_in_range) begin
                res_slot_q <= SLOT_W'(idx_q);
              end
            end
            FUNC_DISPATCH: begin
              if (held_valid_q) begin
                res_slot_q <= held_slot_q;
                res_due_q  <= 1'b1;
              end
            end
            default: begin
              res_slot_q <= SLOT_NONE;
            end
          endcase
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign slot_o         = res_slot_q;
  assign due_o          = res_due_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

endmodule

>>> test/time_triggered_task_scheduler_top_tb.sv
`timescale 1ns / 1ps

// testbench for the time-triggered task scheduler
// a directed table walks the corner cases, then three random phases with
// different amounts of sender idling. every accepted item is run through a
// local copy of the slot table, and every result strobe is checked against
// the oldest expected result

module time_triggered_task_scheduler_top_tb;
  import tts_pkg::*;

  localparam int unsigned TASK_SLOTS = 8;
  localparam logic [3:0]  SLOT_NONE  = 4'(TASK_SLOTS);
  // one rotation of the slot ring plus the closing cycle
  localparam int unsigned ITEM_CYCLES = TASK_SLOTS + 1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_ITEMS  = 72;    // per random phase
  localparam int unsigned DIR_ROWS    = 25;

  // one result of the scheduler, as seen on the result ports
  typedef struct packed {
    logic [3:0] slot;
    logic       due;
    logic       status;
    logic       last;
  } sched_res_t;

  // one row of the directed table
  // typed rows carry a single expected result read straight off the spec,
  // the other rows are checked against the local slot table
  typedef struct packed {
    func_e       op;
    logic [15:0] dly;
    logic [15:0] per;
    logic [2:0]  idx;
    int unsigned reps;
    bit          typed;
    sched_res_t  res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  func_i;
  logic [15:0] delay_i;
  logic [15:0] period_i;
  logic [2:0]  task_index_i;
  logic        result_valid_o;
  logic [3:0]  slot_o;
  logic        due_o;
  logic        status_o;
  logic        last_o;

  // local copy of the slot table
  logic        tab_valid  [TASK_SLOTS];
  logic [15:0] tab_delay  [TASK_SLOTS];
  logic [15:0] tab_period [TASK_SLOTS];
  logic [7:0]  tab_runs   [TASK_SLOTS];

  sched_res_t  step_out[$];       // results of the item just accepted
  sched_res_t  sched_result_q[$]; // results still to come from the block

  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned idle_pct;

  dir_row_t    dir_tab [DIR_ROWS];

  time_triggered_task_scheduler_top #(
    .TASK_SLOTS(TASK_SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .delay_i       (delay_i),
    .period_i      (period_i),
    .task_index_i  (task_index_i),
    .result_valid_o(result_valid_o),
    .slot_o        (slot_o),
    .due_o         (due_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic sched_res_t mk_res(logic [3:0] s, logic d, logic st, logic l);
    sched_res_t r;
    r.slot   = s;
    r.due    = d;
    r.status = st;
    r.last   = l;
    return r;
  endfunction

  function automatic void clear_entry(int unsigned s);
    tab_valid[s]  = 1'b0;
    tab_delay[s]  = '0;
    tab_period[s] = '0;
    tab_runs[s]   = '0;
  endfunction

  // apply one operation to the local slot table, results go to step_out
  function automatic void sched_step(func_e op, logic [15:0] dly, logic [15:0] per,
                                     logic [2:0] idx);
    int unsigned n;
    bit          placed;
    step_out.delete();
    case (op)
      FUNC_TICK: begin
        for (int unsigned s = 0; s < TASK_SLOTS; s++) begin
          if (tab_valid[s]) begin
            if (tab_delay[s] == 16'd0) begin
              // expiry: one more pending run, saturating
              if (tab_runs[s] < RUNS_MAX) tab_runs[s] = tab_runs[s] + 8'd1;
              if (tab_period[s] != 16'd0) tab_delay[s] = tab_period[s];
            end else begin
              tab_delay[s] = tab_delay[s] - 16'd1;
            end
          end
        end
        step_out.push_back(mk_res(SLOT_NONE, 1'b0, 1'b0, 1'b1));
      end
      FUNC_ADD: begin
        placed = 1'b0;
        // lowest free slot wins
        for (int unsigned s = 0; s < TASK_SLOTS; s++) begin
          if (!placed && !tab_valid[s]) begin
            tab_valid[s]  = 1'b1;
            tab_delay[s]  = dly;
            tab_period[s] = per;
            tab_runs[s]   = 8'd0;
            placed = 1'b1;
            step_out.push_back(mk_res(4'(s), 1'b0, 1'b0, 1'b1));
          end
        end
        // table full
        if (!placed) step_out.push_back(mk_res(SLOT_NONE, 1'b0, 1'b1, 1'b1));
      end
      FUNC_DEL: begin
        if (int'(idx) < TASK_SLOTS) begin
          clear_entry(idx);
          step_out.push_back(mk_res(4'(idx), 1'b0, 1'b0, 1'b1));
        end else begin
          step_out.push_back(mk_res(SLOT_NONE, 1'b0, 1'b0, 1'b1));
        end
      end
      default: begin
        n = 0;
        for (int unsigned s = 0; s < TASK_SLOTS; s++) begin
          if (n < MAX_RESULTS && tab_runs[s] != 8'd0) begin
            step_out.push_back(mk_res(4'(s), 1'b1, 1'b0, 1'b0));
            n++;
            tab_runs[s] = tab_runs[s] - 8'd1;
            // one-shot slots are freed once dispatched
            if (tab_period[s] == 16'd0) clear_entry(s);
          end
        end
        if (n == 0) step_out.push_back(mk_res(SLOT_NONE, 1'b0, 1'b0, 1'b1));
        else step_out[step_out.size() - 1].last = 1'b1;
      end
    endcase
  endfunction

  // drive one item, wait for start & !busy, then record what it should give
  // called and returning at a falling edge
  task automatic send_item(func_e op, logic [15:0] dly, logic [15:0] per, logic [2:0] idx,
                           bit typed, sched_res_t tres);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start        = 1'b1;
    func_i       = op;
    delay_i      = dly;
    period_i     = per;
    task_index_i = idx;
    // busy is read before the edge updates it
    do @(posedge clk_i); while (busy);
    sched_step(op, dly, per, idx);
    if (typed) sched_result_q.push_back(tres);
    else foreach (step_out[k]) sched_result_q.push_back(step_out[k]);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int unsigned r;
    func_e       op;
    logic [15:0] dly;
    logic [15:0] per;
    r = $urandom_range(99);
    if (r < 45)      op = FUNC_TICK;
    else if (r < 65) op = FUNC_ADD;
    else if (r < 75) op = FUNC_DEL;
    else             op = FUNC_DISPATCH;
    // mostly short delays and periods so that slots fire often
    if ($urandom_range(99) < 80) dly = 16'($urandom_range(6));
    else                         dly = 16'($urandom_range(65535));
    r = $urandom_range(99);
    if (r < 30)      per = 16'd0;
    else if (r < 85) per = 16'($urandom_range(5, 1));
    else             per = 16'($urandom_range(65535));
    send_item(op, dly, per, 3'($urandom_range(7)), 1'b0, '0);
  endtask

  // hold off the next item until every expected result has come
  task automatic drain();
    start = 1'b0;
    while (sched_result_q.size() != 0) @(negedge clk_i);
  endtask

  // result checker, sampled at the rising edge
  always @(posedge clk_i) begin
    sched_result_q = sched_result_q;
    if (rst_ni && result_valid_o) begin
      if (sched_result_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result: slot=%0d due=%0b status=%0b last=%0b",
                   slot_o, due_o, status_o, last_o);
        mismatch_cnt++;
      end else begin
        if (sched_result_q[0] !== {slot_o, due_o, status_o, last_o}) begin
          if (mismatch_cnt < 10)
            $display({"result mismatch: exp slot=%0d due=%0b status=%0b last=%0b,",
                      " got slot=%0d due=%0b status=%0b last=%0b"},
                     sched_result_q[0].slot, sched_result_q[0].due,
                     sched_result_q[0].status, sched_result_q[0].last,
                     slot_o, due_o, status_o, last_o);
          mismatch_cnt++;
        end
        void'(sched_result_q.pop_front());
      end
    end
  end

  // runaway guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    start        = 1'b0;
    func_i       = FUNC_TICK;
    delay_i      = '0;
    period_i     = '0;
    task_index_i = '0;
    rst_ni       = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    idle_pct     = 18;
    for (int unsigned s = 0; s < TASK_SLOTS; s++) clear_entry(s);

    // directed rows
    dir_tab = '{
      // empty table: tick and dispatch give nothing
      '{FUNC_TICK,     16'h0000, 16'h0000, 3'd0, 1, 1'b1, {SLOT_NONE, 1'b0, 1'b0, 1'b1}},
      '{FUNC_DISPATCH, 16'h0000, 16'h0000, 3'd0, 1, 1'b1, {SLOT_NONE, 1'b0, 1'b0, 1'b1}},
      // fill the table in slot order, field extremes included
      '{FUNC_ADD,      16'h0000, 16'h0000, 3'd0, 1, 1'b1, {4'd0, 1'b0, 1'b0, 1'b1}},
      '{FUNC_ADD,      16'hffff, 16'hffff, 3'd7, 1, 1'b1, {4'd1, 1'b0, 1'b0, 1'b1}},
      '{FUNC_ADD,      16'h0001, 16'h0001, 3'd0, 1, 1'b1, {4'd2, 1'b0, 1'b0, 1'b1}},
      '{FUNC_ADD,      16'h0000, 16'h0002, 3'd0, 1, 1'b1, {4'd3, 1'b0, 1'b0, 1'b1}},
      '{FUNC_ADD,      16'h0002, 16'h0000, 3'd0, 1, 1'b1, {4'd4, 1'b0, 1'b0, 1'b1}},
      '{FUNC_ADD,      16'h0000, 16'h8000, 3'd0, 1, 1'b1, {4'd5, 1'b0, 1'b0, 1'b1}},
      '{FUNC_ADD,      16'h5555, 16'haaaa, 3'd0, 1, 1'b1, {4'd6, 1'b0, 1'b0, 1'b1}},
      '{FUNC_ADD,      16'haaaa, 16'h5555, 3'd0, 1, 1'b1, {4'd7, 1'b0, 1'b0, 1'b1}},
      // table full
      '{FUNC_ADD,      16'h1234, 16'h0001, 3'd0, 1, 1'b1, {SLOT_NONE, 1'b0, 1'b1, 1'b1}},
      '{FUNC_TICK,     16'h0000, 16'h0000, 3'd0, 1, 1'b0, '0},
      '{FUNC_TICK,     16'h0000, 16'h0000, 3'd0, 1, 1'b0, '0},
      '{FUNC_DISPATCH, 16'h0000, 16'h0000, 3'd0, 1, 1'b0, '0},
      // long tick run: one-shot slot keeps counting and saturates
      '{FUNC_TICK,     16'h0000, 16'h0000, 3'd0, 260, 1'b0, '0},
      '{FUNC_DISPATCH, 16'h0000, 16'h0000, 3'd0, 1, 1'b0, '0},
      '{FUNC_DISPATCH, 16'h0000, 16'h0000, 3'd0, 1, 1'b0, '0},
      '{FUNC_DEL,      16'h0000, 16'h0000, 3'd7, 1, 1'b1, {4'd7, 1'b0, 1'b0, 1'b1}},
      '{FUNC_DEL,      16'hffff, 16'hffff, 3'd0, 1, 1'b1, {4'd0, 1'b0, 1'b0, 1'b1}},
      '{FUNC_ADD,      16'h0000, 16'h0000, 3'd0, 1, 1'b0, '0},
      '{FUNC_DEL,      16'h0000, 16'h0000, 3'd5, 1, 1'b1, {4'd5, 1'b0, 1'b0, 1'b1}},
      '{FUNC_TICK,     16'h0000, 16'h0000, 3'd0, 1, 1'b0, '0},
      '{FUNC_DISPATCH, 16'h0000, 16'h0000, 3'd0, 1, 1'b0, '0},
      // delete of a free-or-busy slot with junk in the unused fields
      '{FUNC_DEL,      16'hbeef, 16'h00ff, 3'd2, 1, 1'b1, {4'd2, 1'b0, 1'b0, 1'b1}},
      '{FUNC_DISPATCH, 16'h0000, 16'h0000, 3'd0, 1, 1'b0, '0}
    };

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i])
      repeat (dir_tab[i].reps)
        send_item(dir_tab[i].op, dir_tab[i].dly, dir_tab[i].per, dir_tab[i].idx,
                  dir_tab[i].typed, dir_tab[i].res);

    // random phases: light sender idling, heavy idling, back to back
    drain();
    repeat (RAND_ITEMS) send_random();
    drain();
    idle_pct = 73;
    repeat (RAND_ITEMS) send_random();
    drain();
    idle_pct = 0;
    repeat (RAND_ITEMS) send_random();

    drain();
    // keep the clock running after the drain to catch stray results
    repeat (3 * ITEM_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0 && sched_result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> time_triggered_task_scheduler_top.f
hdl/tts_pkg.sv
hdl/tts_cell.sv
hdl/tts_slot_op.sv
hdl/time_triggered_task_scheduler_top.sv
test/time_triggered_task_scheduler_top_tb.sv
